FILE: rtl/vfc_pkg.sv
// Shared types, constants and helpers of the voxel face culling mesher.
// Used by every module in rtl/ except vfc_ram; depends on nothing else.
`timescale 1ns / 1ps

package vfc_pkg;

	// Chunk geometry and store sizes.
	localparam int CHUNK_WIDTH  = 16;
	localparam int CHUNK_DEPTH  = 16;
	localparam int CHUNK_HEIGHT = 256;
	localparam int TYPE_BITS    = 8;

	localparam int VOXEL_COUNT = CHUNK_WIDTH * CHUNK_DEPTH * CHUNK_HEIGHT;
	localparam int EDGE_SPAN   = (CHUNK_WIDTH > CHUNK_DEPTH) ? CHUNK_WIDTH : CHUNK_DEPTH;
	localparam int EDGE_COUNT  = 4 * EDGE_SPAN * CHUNK_HEIGHT;
	localparam int VOX_AW      = $clog2(VOXEL_COUNT);
	localparam int EDGE_AW     = $clog2(EDGE_COUNT);
	localparam int VOX_W       = TYPE_BITS + 1;

	// Address steps between neighbouring cells: cell = (y*W + x)*D + z.
	localparam int X_STEP = CHUNK_DEPTH;
	localparam int Y_STEP = CHUNK_WIDTH * CHUNK_DEPTH;

	// Fixed field widths.
	localparam int WORLD_W = 20;
	localparam int INDEX_W = 22;
	localparam int FACES   = 6;

	// Queues.
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Configuration port.
	localparam int NUM_REGS  = 3;
	localparam int PADDR_W   = $clog2(4 * NUM_REGS);
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam int PDATA_W   = 32;

	// Mesh read sequence: four paired reads, the last data captured in the cycle after its read.
	localparam int RD_W    = 3;
	localparam int RD_LAST = 4;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CHUNK_POS_X     = 2'd0,
		REG_CHUNK_POS_Z     = 2'd1,
		REG_NEIGHBOUR_PRES  = 2'd2
	} reg_e;

	typedef enum logic [1:0] {
		CMD_WRITE_VOXEL = 2'd0,
		CMD_WRITE_EDGE  = 2'd1,
		CMD_MESH        = 2'd2,
		CMD_CLEAR_INDEX = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		SIDE_RIGHT = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_FRONT = 2'd2,
		SIDE_BACK  = 2'd3
	} side_e;

	typedef enum logic [2:0] {
		FACE_RIGHT  = 3'd0,
		FACE_LEFT   = 3'd1,
		FACE_FRONT  = 3'd2,
		FACE_BACK   = 3'd3,
		FACE_TOP    = 3'd4,
		FACE_BOTTOM = 3'd5
	} face_e;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_WR_VOXEL,
		OP_WR_EDGE,
		OP_MESH,
		OP_CLEAR
	} op_kind_e;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} bk_state_e;

	typedef struct packed {
		cmd_e       command;
		logic [3:0] pos_x;
		logic [7:0] pos_y;
		logic [3:0] pos_z;
		side_e      edge_side;
		logic [7:0] voxel_type;
		logic       is_solid;
	} item_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] world_x;
		logic [7:0]                world_y;
		logic signed [WORLD_W-1:0] world_z;
		logic [2:0]                face_code;
		logic [7:0]                face_type;
		logic [INDEX_W-1:0]        base_index;
		logic                      last_face;
	} result_t;

	typedef struct packed {
		logic signed [15:0] chunk_pos_x;
		logic signed [15:0] chunk_pos_z;
		logic [3:0]         neighbour_present;
	} cfg_t;

	// Which chunk borders a voxel touches.
	typedef struct packed {
		logic x_max;
		logic x_min;
		logic z_min;
		logic z_max;
		logic y_max;
		logic y_min;
	} bound_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		op_kind_e               kind;
		logic [VOX_AW-1:0]      vox_addr;
		logic [EDGE_AW-1:0]     edge_a;
		logic [EDGE_AW-1:0]     edge_b;
		logic [TYPE_BITS-1:0]   vtype;
		logic                   solid;
		bound_t                 bound;
		logic [3:0]             present;
		logic [7:0]             pos_y;
		logic [WORLD_W-1:0]     world_x;
		logic [WORLD_W-1:0]     world_z;
	} op_t;

	function automatic logic [EDGE_AW-1:0] edge_addr(side_e s, int coord, int y);
		return EDGE_AW'((int'(s) * EDGE_SPAN + coord) * CHUNK_HEIGHT + y);
	endfunction

	// Lowest exposed face still pending.
	function automatic face_e lowest_face(logic [FACES-1:0] m);
		face_e f;
		if (m[0])      f = FACE_RIGHT;
		else if (m[1]) f = FACE_LEFT;
		else if (m[2]) f = FACE_FRONT;
		else if (m[3]) f = FACE_BACK;
		else if (m[4]) f = FACE_TOP;
		else           f = FACE_BOTTOM;
		return f;
	endfunction

endpackage

FILE: rtl/vfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the voxel and edge stores.
`timescale 1ns / 1ps

module vfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/vfc_front.sv
// Front end: accepts items, decodes and range-checks them, computes store
// addresses and world coordinates, and queues the result for the back end. Uses vfc_pkg.
`timescale 1ns / 1ps

module vfc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  vfc_pkg::item_t item,
	input  vfc_pkg::cfg_t  cfg,
	output logic           op_valid,
	input  logic           op_take,
	output vfc_pkg::op_t   op
);
	import vfc_pkg::*;

	op_t              cls;
	op_t              slot_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_q;
	logic [FQ_AW-1:0] rd_q;
	logic [FQ_AW:0]   cnt_q;
	logic             in_chunk;
	logic             edge_ok;
	logic             do_push;
	logic             do_pop;
	int               x;
	int               y;
	int               z;
	logic [WORLD_W-1:0] wx;
	logic [WORLD_W-1:0] wz;

	always_comb begin
		x = int'(item.pos_x);
		y = int'(item.pos_y);
		z = int'(item.pos_z);
		in_chunk = (x < CHUNK_WIDTH) && (y < CHUNK_HEIGHT) && (z < CHUNK_DEPTH);
		if (item.edge_side inside {SIDE_RIGHT, SIDE_LEFT}) begin
			edge_ok = (z < CHUNK_DEPTH) && (y < CHUNK_HEIGHT);
		end else begin
			edge_ok = (x < CHUNK_WIDTH) && (y < CHUNK_HEIGHT);
		end
		wx = WORLD_W'(int'(cfg.chunk_pos_x) * CHUNK_WIDTH) + WORLD_W'(item.pos_x);
		wz = WORLD_W'(int'(cfg.chunk_pos_z) * CHUNK_DEPTH) + WORLD_W'(item.pos_z);

		cls.bound.x_max = (x + 1 == CHUNK_WIDTH);
		cls.bound.x_min = (x == 0);
		cls.bound.z_min = (z == 0);
		cls.bound.z_max = (z + 1 == CHUNK_DEPTH);
		cls.bound.y_max = (y + 1 == CHUNK_HEIGHT);
		cls.bound.y_min = (y == 0);
		cls.vox_addr = VOX_AW'((y * CHUNK_WIDTH + x) * CHUNK_DEPTH + z);
		cls.vtype    = TYPE_BITS'(item.voxel_type);
		cls.solid    = item.is_solid;
		cls.present  = cfg.neighbour_present;
		cls.pos_y    = item.pos_y;
		cls.world_x  = wx;
		cls.world_z  = wz;
		cls.edge_b   = cls.bound.z_min ? edge_addr(SIDE_FRONT, x, y)
		                               : edge_addr(SIDE_BACK, x, y);

		unique case (item.command)
			CMD_WRITE_VOXEL: begin
				cls.kind   = in_chunk ? OP_WR_VOXEL : OP_NOP;
				cls.edge_a = edge_addr(SIDE_RIGHT, z, y);
			end
			CMD_WRITE_EDGE: begin
				cls.kind   = edge_ok ? OP_WR_EDGE : OP_NOP;
				cls.edge_a = (item.edge_side inside {SIDE_RIGHT, SIDE_LEFT})
				             ? edge_addr(item.edge_side, z, y)
				             : edge_addr(item.edge_side, x, y);
			end
			CMD_MESH: begin
				cls.kind   = in_chunk ? OP_MESH : OP_NOP;
				cls.edge_a = cls.bound.x_max ? edge_addr(SIDE_RIGHT, z, y)
				                             : edge_addr(SIDE_LEFT, z, y);
			end
			CMD_CLEAR_INDEX: begin
				cls.kind   = OP_CLEAR;
				cls.edge_a = edge_addr(SIDE_RIGHT, z, y);
			end
			default: begin
				cls.kind   = OP_NOP;
				cls.edge_a = edge_addr(SIDE_RIGHT, z, y);
			end
		endcase
	end

	assign full     = (cnt_q == (FQ_AW + 1)'(FQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = slot_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = op_take && op_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/vfc_back.sv
// Back end: executes queued commands against the voxel and edge stores and
// sequences the neighbour reads and face records of a mesh command. Uses vfc_pkg, vfc_ram.
`timescale 1ns / 1ps

module vfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_take,
	input  vfc_pkg::op_t     op,
	output logic             rec_push,
	input  logic             rec_full,
	output vfc_pkg::result_t rec
);
	import vfc_pkg::*;

	bk_state_e            state_q;
	bk_state_e            state_d;
	op_t                  op_q;
	logic [RD_W-1:0]      rd_q;
	logic [TYPE_BITS-1:0] self_type_q;
	logic                 self_solid_q;
	logic                 right_q;
	logic                 left_q;
	logic                 front_q;
	logic                 back_q;
	logic                 top_q;
	logic                 edge_x_q;
	logic                 edge_z_q;
	logic [FACES-1:0]     mask_q;
	logic [FACES-1:0]     mask_d;
	logic [INDEX_W-1:0]   index_q;

	logic                 vox_we;
	logic                 edge_we;
	logic [VOX_AW-1:0]    raddr_a;
	logic [VOX_AW-1:0]    raddr_b;
	logic [EDGE_AW-1:0]   edge_raddr;
	logic [VOX_W-1:0]     rdata_a;
	logic [VOX_W-1:0]     rdata_b;
	logic                 edge_rdata;
	logic                 last;

	// Two copies of the voxel store give two reads per cycle.
	vfc_ram #(.WIDTH(VOX_W), .DEPTH(VOXEL_COUNT)) u_vox_a (
		.clk   (clk),
		.we    (vox_we),
		.waddr (op.vox_addr),
		.wdata ({op.solid, op.vtype}),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	vfc_ram #(.WIDTH(VOX_W), .DEPTH(VOXEL_COUNT)) u_vox_b (
		.clk   (clk),
		.we    (vox_we),
		.waddr (op.vox_addr),
		.wdata ({op.solid, op.vtype}),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	vfc_ram #(.WIDTH(1), .DEPTH(EDGE_COUNT)) u_edge (
		.clk   (clk),
		.we    (edge_we),
		.waddr (op.edge_a),
		.wdata (op.solid),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// Neighbour addresses may wrap at a chunk border; those reads are ignored.
	always_comb begin
		raddr_a    = op_q.vox_addr;
		raddr_b    = op_q.vox_addr;
		edge_raddr = op_q.edge_a;
		case (rd_q)
			RD_W'(0): begin
				raddr_b = op_q.vox_addr + VOX_AW'(X_STEP);
			end
			RD_W'(1): begin
				raddr_a    = op_q.vox_addr - VOX_AW'(X_STEP);
				raddr_b    = op_q.vox_addr - VOX_AW'(1);
				edge_raddr = op_q.edge_b;
			end
			RD_W'(2): begin
				raddr_a = op_q.vox_addr + VOX_AW'(1);
				raddr_b = op_q.vox_addr + VOX_AW'(Y_STEP);
			end
			RD_W'(3): begin
				raddr_a = op_q.vox_addr - VOX_AW'(Y_STEP);
			end
			default: begin
			end
		endcase
	end

	// Exposure mask, formed when the bottom neighbour arrives.
	always_comb begin
		mask_d[FACE_RIGHT]  = op_q.bound.x_max ? (op_q.present[SIDE_RIGHT] && !edge_x_q)
		                                       : !right_q;
		mask_d[FACE_LEFT]   = op_q.bound.x_min ? (op_q.present[SIDE_LEFT] && !edge_x_q)
		                                       : !left_q;
		mask_d[FACE_FRONT]  = op_q.bound.z_min ? (op_q.present[SIDE_FRONT] && !edge_z_q)
		                                       : !front_q;
		mask_d[FACE_BACK]   = op_q.bound.z_max ? (op_q.present[SIDE_BACK] && !edge_z_q)
		                                       : !back_q;
		mask_d[FACE_TOP]    = op_q.bound.y_max || !top_q;
		mask_d[FACE_BOTTOM] = !op_q.bound.y_min && !rdata_a[TYPE_BITS];
		if (!self_solid_q) begin
			mask_d = '0;
		end
	end

	assign last = ((mask_q & (mask_q - 1'b1)) == '0);

	always_comb begin
		rec.world_x    = op_q.world_x;
		rec.world_y    = op_q.pos_y;
		rec.world_z    = op_q.world_z;
		rec.face_code  = lowest_face(mask_q);
		rec.face_type  = 8'(self_type_q);
		rec.base_index = index_q;
		rec.last_face  = last;
	end

	always_comb begin
		state_d  = state_q;
		op_take  = 1'b0;
		vox_we   = 1'b0;
		edge_we  = 1'b0;
		rec_push = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (op_valid) begin
					op_take = 1'b1;
					unique case (op.kind)
						OP_WR_VOXEL: vox_we  = 1'b1;
						OP_WR_EDGE:  edge_we = 1'b1;
						OP_MESH:     state_d = BK_READ;
						default: begin
						end
					endcase
				end
			end
			BK_READ: begin
				if (rd_q == RD_W'(RD_LAST)) begin
					state_d = (mask_d != '0) ? BK_EMIT : BK_IDLE;
				end
			end
			BK_EMIT: begin
				if (!rec_full) begin
					rec_push = 1'b1;
					if (last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			op_q <= op;
		end
		case (rd_q)
			RD_W'(1): begin
				self_type_q  <= rdata_a[TYPE_BITS-1:0];
				self_solid_q <= rdata_a[TYPE_BITS];
				right_q      <= rdata_b[TYPE_BITS];
				edge_x_q     <= edge_rdata;
			end
			RD_W'(2): begin
				left_q   <= rdata_a[TYPE_BITS];
				front_q  <= rdata_b[TYPE_BITS];
				edge_z_q <= edge_rdata;
			end
			RD_W'(3): begin
				back_q <= rdata_a[TYPE_BITS];
				top_q  <= rdata_b[TYPE_BITS];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rd_q    <= '0;
			mask_q  <= '0;
			index_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_READ) begin
				rd_q <= rd_q + 1'b1;
			end else begin
				rd_q <= '0;
			end
			if (state_q == BK_READ && rd_q == RD_W'(RD_LAST)) begin
				mask_q <= mask_d;
			end else if (rec_push) begin
				mask_q <= mask_q & (mask_q - 1'b1);
			end
			if (op_take && op.kind == OP_CLEAR) begin
				index_q <= '0;
			end else if (rec_push) begin
				index_q <= index_q + INDEX_W'(4);
			end
		end
	end

endmodule

FILE: rtl/vfc_out_queue.sv
// Result queue between the back end and the result port.
// Register-based, OQ_DEPTH beats deep. Uses vfc_pkg.
`timescale 1ns / 1ps

module vfc_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  vfc_pkg::result_t rec_in,
	input  logic             pop,
	output logic             empty,
	output vfc_pkg::result_t rec_out
);
	import vfc_pkg::*;

	result_t          slot_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_q;
	logic [OQ_AW-1:0] rd_q;
	logic [OQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (OQ_AW + 1)'(OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rec_out = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= rec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/voxel_face_culling_mesher_unit.sv
// Voxel face culling mesher. Writes, edge writes and index clears are done in the cycle
// in which the back end takes them. A mesh command is taken, runs its paired store reads
// on the two voxel read ports, then pushes one face beat per cycle for each exposed face
// while the result queue is not full; no new command is taken until the mesh is done.
// Reset clears the queues, the sequencer, the index counter and the registers; the voxel
// and edge stores are not cleared and hold nothing defined until written.
`timescale 1ns / 1ps

module voxel_face_culling_mesher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  vfc_pkg::item_t                  item,
	output logic                            empty,
	input  logic                            pop,
	output vfc_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vfc_pkg::PADDR_W-1:0]     paddr,
	input  logic [vfc_pkg::PDATA_W-1:0]     pwdata,
	output logic [vfc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import vfc_pkg::*;

	cfg_t    cfg_q;
	reg_e    reg_idx;
	logic    cfg_we;
	logic    op_valid;
	logic    op_take;
	op_t     op;
	logic    rec_push;
	logic    rec_full;
	result_t rec;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_CHUNK_POS_X:    cfg_q.chunk_pos_x       <= pwdata[15:0];
				REG_CHUNK_POS_Z:    cfg_q.chunk_pos_z       <= pwdata[15:0];
				REG_NEIGHBOUR_PRES: cfg_q.neighbour_present <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHUNK_POS_X:    prdata = PDATA_W'(cfg_q.chunk_pos_x);
			REG_CHUNK_POS_Z:    prdata = PDATA_W'(cfg_q.chunk_pos_z);
			REG_NEIGHBOUR_PRES: prdata = PDATA_W'(cfg_q.neighbour_present);
			default:            prdata = '0;
		endcase
	end

	vfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg      (cfg_q),
		.op_valid (op_valid),
		.op_take  (op_take),
		.op       (op)
	);

	vfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_take  (op_take),
		.op       (op),
		.rec_push (rec_push),
		.rec_full (rec_full),
		.rec      (rec)
	);

	vfc_out_queue u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.full    (rec_full),
		.rec_in  (rec),
		.pop     (pop),
		.empty   (empty),
		.rec_out (result)
	);

	// The back end never drops a face beat into a full result queue.
	a_no_rec_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !rec_full)
		else $error("face beat pushed into a full result queue");

	// Commands are only taken from a non-empty front queue.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_valid)
		else $error("back end took a command from an empty queue");

	// Consecutive faces of one voxel advance the base index by four.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push && $past(rec_push) && !$past(rec.last_face)
		|-> rec.base_index == $past(rec.base_index) + INDEX_W'(4))
		else $error("base index did not advance by four between faces");

endmodule
